// ----- src/owm_pkg.sv -----
package owm_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int REQ_BITS       = 2;
	localparam int BYTE_BITS      = 8;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;

	localparam logic [REQ_BITS-1:0] REQ_TICK  = 2'd0;
	localparam logic [REQ_BITS-1:0] REQ_RESET = 2'd1;
	localparam logic [REQ_BITS-1:0] REQ_WRITE = 2'd2;
	localparam logic [REQ_BITS-1:0] REQ_READ  = 2'd3;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_RESET_LOW     = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_PRESENCE_WAIT = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_POST_PRESENCE = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SLOT          = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SHORT_LOW     = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_RECOVERY      = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SAMPLE_DELAY  = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_RETRY         = 3'd7;

	typedef struct packed {
		logic [15:0] reset_low_ticks;
		logic [15:0] presence_wait_ticks;
		logic [15:0] post_presence_ticks;
		logic [15:0] slot_ticks;
		logic [7:0]  short_low_ticks;
		logic [7:0]  recovery_ticks;
		logic [7:0]  sample_delay_ticks;
		logic        retry_until_present;
	} cfg_t;

	localparam cfg_t CFG_RESET_VALUE = '{
		reset_low_ticks:     16'd500,
		presence_wait_ticks: 16'd100,
		post_presence_ticks: 16'd60,
		slot_ticks:          16'd60,
		short_low_ticks:     8'd2,
		recovery_ticks:      8'd6,
		sample_delay_ticks:  8'd0,
		retry_until_present: 1'b1
	};

	typedef struct packed {
		logic                 drive_low;
		logic                 busy_res;
		logic                 done_res;
		logic                 presence;
		logic [BYTE_BITS-1:0] read_byte;
		logic                 rejected;
	} res_t;

endpackage

// ----- src/owm_tick_if.sv -----
interface owm_tick_if
	import owm_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [REQ_BITS-1:0]  req_type;
	logic [BYTE_BITS-1:0] write_byte;
	logic                 line_level;

	modport source (output valid, output req_type, output write_byte, output line_level,
		input ready);
	modport sink (input valid, input req_type, input write_byte, input line_level,
		output ready);
endinterface

// ----- src/owm_status_if.sv -----
interface owm_status_if
	import owm_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic                 drive_low;
	logic                 busy_res;
	logic                 done_res;
	logic                 presence;
	logic [BYTE_BITS-1:0] read_byte;
	logic                 rejected;

	modport source (output valid, output drive_low, output busy_res, output done_res,
		output presence, output read_byte, output rejected, input ready);
	modport sink (input valid, input drive_low, input busy_res, input done_res,
		input presence, input read_byte, input rejected, output ready);
endinterface

// ----- src/owm_cfg_regs.sv -----
module owm_cfg_regs
	import owm_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET_VALUE;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RESET_LOW:     cfg_q.reset_low_ticks     <= cfg_data;
				CFG_PRESENCE_WAIT: cfg_q.presence_wait_ticks <= cfg_data;
				CFG_POST_PRESENCE: cfg_q.post_presence_ticks <= cfg_data;
				CFG_SLOT:          cfg_q.slot_ticks          <= cfg_data;
				CFG_SHORT_LOW:     cfg_q.short_low_ticks     <= cfg_data[7:0];
				CFG_RECOVERY:      cfg_q.recovery_ticks      <= cfg_data[7:0];
				CFG_SAMPLE_DELAY:  cfg_q.sample_delay_ticks  <= cfg_data[7:0];
				CFG_RETRY:         cfg_q.retry_until_present <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- src/owm_core.sv -----
module owm_core
	import owm_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [REQ_BITS-1:0]  req_type,
	input  logic [BYTE_BITS-1:0] write_byte,
	input  logic                 line_level,
	input  cfg_t                 cfg,
	output res_t                 res
);

	localparam int VW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [3:0] PH_IDLE       = 4'd0;
	localparam logic [3:0] PH_RST_LOW    = 4'd1;
	localparam logic [3:0] PH_RST_WAIT   = 4'd2;
	localparam logic [3:0] PH_RST_POST   = 4'd3;
	localparam logic [3:0] PH_SLOT_LOW   = 4'd4;
	localparam logic [3:0] PH_SLOT_HIGH  = 4'd5;
	localparam logic [3:0] PH_READ_DELAY = 4'd6;
	localparam logic [3:0] PH_READ_TAIL  = 4'd7;
	localparam logic [3:0] PH_RECOVER    = 4'd8;

	logic [3:0]            phase_q;
	logic [COUNT_BITS-1:0] tick_q;
	logic [2:0]            bit_q;
	logic [BYTE_BITS-1:0]  shift_q;
	logic [REQ_BITS-1:0]   op_q;
	logic                  present_q;
	logic [BYTE_BITS-1:0]  last_read_q;

	logic [3:0]            ph;
	logic [COUNT_BITS-1:0] tc;
	logic [COUNT_BITS:0]   tc_inc;
	logic [COUNT_BITS-1:0] len;
	logic [2:0]            bi;
	logic [BYTE_BITS-1:0]  sb;
	logic [REQ_BITS-1:0]   ok;
	logic                  pf;
	logic [BYTE_BITS-1:0]  lr;
	logic                  going;

	function automatic logic [COUNT_BITS-1:0] clampd(input logic [15:0] v, input logic lo1);
		logic [VW-1:0] ext;
		ext = VW'(v);
		if (lo1 && v == 16'd0) ext = VW'(1);
		if (ext > VW'(COUNT_MAX)) ext = VW'(COUNT_MAX);
		return ext[COUNT_BITS-1:0];
	endfunction

	function automatic logic [COUNT_BITS-1:0] phase_len(input logic [3:0] p,
		input logic [REQ_BITS-1:0] op, input logic lsb, input cfg_t c);
		logic [COUNT_BITS-1:0] r;
		case (p)
			PH_RST_LOW:    r = clampd(c.reset_low_ticks, 1'b1);
			PH_RST_WAIT:   r = clampd(c.presence_wait_ticks, 1'b1);
			PH_RST_POST:   r = clampd(c.post_presence_ticks, 1'b0);
			PH_SLOT_LOW: begin
				if (op == REQ_WRITE && !lsb) r = clampd(c.slot_ticks, 1'b1);
				else r = clampd({8'd0, c.short_low_ticks}, 1'b1);
			end
			PH_SLOT_HIGH:  r = clampd(c.slot_ticks, 1'b1);
			PH_READ_DELAY: r = clampd({8'd0, c.sample_delay_ticks}, 1'b0);
			PH_READ_TAIL:  r = clampd(c.slot_ticks, 1'b1);
			PH_RECOVER:    r = clampd({8'd0, c.recovery_ticks}, 1'b0);
			default:       r = COUNT_BITS'(1);
		endcase
		return r;
	endfunction

	always_comb begin
		ph = phase_q;
		tc = tick_q;
		bi = bit_q;
		sb = shift_q;
		ok = op_q;
		pf = present_q;
		lr = last_read_q;
		tc_inc = '0;
		len = '0;
		going = 1'b0;
		res = '0;

		if (req_type != REQ_TICK) begin
			if (phase_q != PH_IDLE) begin
				res.rejected = 1'b1;
			end else begin
				ok = req_type;
				tc = '0;
				bi = '0;
				if (req_type == REQ_RESET) begin
					pf = 1'b0;
					ph = PH_RST_LOW;
				end else begin
					sb = (req_type == REQ_WRITE) ? write_byte : '0;
					ph = PH_SLOT_LOW;
				end
			end
		end

		if (ph != PH_IDLE) begin
			len = phase_len(ph, ok, sb[0], cfg);
			res.busy_res = 1'b1;
			res.drive_low = (ph == PH_RST_LOW) || (ph == PH_SLOT_LOW);
			tc_inc = {1'b0, tc} + 1'b1;
			if (ph == PH_RST_WAIT && tc_inc >= {1'b0, len}) pf = ~line_level;
			if (ph == PH_READ_TAIL && tc == '0) sb = {line_level, sb[BYTE_BITS-1:1]};
			tc = tc_inc[COUNT_BITS-1:0];
			if (tc >= len || tc == '0) begin
				tc = '0;
				going = 1'b1;
				// zero-length phases are passed in the same tick; at most two hops
				for (int k = 0; k < 2; k++) begin
					if (going) begin
						case (ph)
							PH_RST_LOW: ph = PH_RST_WAIT;
							PH_RST_WAIT: begin
								if (pf) ph = PH_RST_POST;
								else if (cfg.retry_until_present) ph = PH_RST_LOW;
								else ph = PH_IDLE;
							end
							PH_SLOT_LOW: begin
								if (ok == REQ_READ) ph = PH_READ_DELAY;
								else if (sb[0]) ph = PH_SLOT_HIGH;
								else ph = PH_RECOVER;
							end
							PH_SLOT_HIGH:  ph = PH_RECOVER;
							PH_READ_DELAY: ph = PH_READ_TAIL;
							PH_READ_TAIL:  ph = PH_RECOVER;
							PH_RECOVER: begin
								if (ok == REQ_WRITE) sb = {1'b0, sb[BYTE_BITS-1:1]};
								if (bi == 3'd7) begin
									if (ok == REQ_READ) lr = sb;
									ph = PH_IDLE;
								end else begin
									bi = bi + 3'd1;
									ph = PH_SLOT_LOW;
								end
							end
							default: ph = PH_IDLE;
						endcase
						if (ph == PH_IDLE) begin
							going = 1'b0;
							res.done_res = 1'b1;
						end else if (phase_len(ph, ok, sb[0], cfg) != '0) begin
							going = 1'b0;
						end
					end
				end
			end
		end

		res.presence = pf;
		res.read_byte = lr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q <= '0;
			bit_q <= '0;
			shift_q <= '0;
			op_q <= '0;
			present_q <= 1'b0;
			last_read_q <= '0;
		end else if (fire) begin
			phase_q <= ph;
			tick_q <= tc;
			bit_q <= bi;
			shift_q <= sb;
			op_q <= ok;
			present_q <= pf;
			last_read_q <= lr;
		end
	end

endmodule

// ----- src/one_wire_bus_master.sv -----
// An accepted tick transaction reaches its status transaction through the input register, then
// the result register; both hold while a status transaction waits for the status side.
// Throughput: one tick per cycle while the status side takes each result.
// Reset (arst_n low, asynchronous): bus sequencer idle, counters and flags cleared,
// configuration registers back to their default timings.
module one_wire_bus_master
	import owm_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	owm_tick_if.sink                  tick,
	owm_status_if.source              status,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	cfg_t                 cfg;
	res_t                 res;
	res_t                 res_q;
	logic                 res_valid_q;
	logic                 valid_s1;
	logic [REQ_BITS-1:0]  req_s1;
	logic [BYTE_BITS-1:0] wbyte_s1;
	logic                 line_s1;
	logic                 fire;

	assign fire = valid_s1 && (!res_valid_q || status.ready);
	assign tick.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			req_s1 <= tick.req_type;
			wbyte_s1 <= tick.write_byte;
			line_s1 <= tick.line_level;
		end
	end

	owm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	owm_core #(
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.req_type   (req_s1),
		.write_byte (wbyte_s1),
		.line_level (line_s1),
		.cfg        (cfg),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (status.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign status.valid     = res_valid_q;
	assign status.drive_low = res_q.drive_low;
	assign status.busy_res  = res_q.busy_res;
	assign status.done_res  = res_q.done_res;
	assign status.presence  = res_q.presence;
	assign status.read_byte = res_q.read_byte;
	assign status.rejected  = res_q.rejected;

endmodule

// ----- sim/tb_one_wire_bus_master.sv -----
module tb_one_wire_bus_master;
	import owm_pkg::*;

	localparam int unsigned COUNT_MAX   = (1 << COUNT_BITS_DEF) - 1;
	localparam int          QUIET_LIMIT = 5000;
	localparam logic [1:0]  SET_DEFAULT = 2'd0;
	localparam logic [1:0]  SET_SMALL   = 2'd1;
	localparam logic [1:0]  SET_ZERO    = 2'd2;
	localparam logic [1:0]  SET_MASK    = 2'd3;
	localparam int          RAND_SETS   = 5;
	localparam int          RAND_ITEMS  = 185;

	typedef enum logic [3:0] {
		SEQ_IDLE, SEQ_RST_LOW, SEQ_RST_WAIT, SEQ_RST_POST, SEQ_SLOT_LOW,
		SEQ_SLOT_HIGH, SEQ_READ_DELAY, SEQ_READ_TAIL, SEQ_RECOVER
	} seq_phase_e;

	typedef logic [7:0][CFG_DATA_BITS-1:0] timing_t;

	typedef struct {
		logic [1:0]           set;
		logic [REQ_BITS-1:0]  rq;
		logic [BYTE_BITS-1:0] wb;
		logic                 ln;
		bit                   fin;
		bit                   chk;
		res_t                 exp;
	} stim_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	owm_tick_if   tick_bus ();
	owm_status_if status_bus ();

	one_wire_bus_master u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_bus),
		.status    (status_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// bus sequencer mirror
	cfg_t                 mirror;
	seq_phase_e           seq_phase;
	int unsigned          seq_count;
	logic [2:0]           seq_bit;
	logic [BYTE_BITS-1:0] seq_shift;
	logic [REQ_BITS-1:0]  seq_op;
	logic                 seq_present;
	logic [BYTE_BITS-1:0] seq_last;

	res_t      pending_status [$];
	res_t      got_status;
	res_t      want_status;
	stim_row_t plan [$];
	timing_t   cfg_sets [4];
	bit        calm;
	logic [1:0] cur_set;
	int        quiet;
	int        n_errors, n_checked, n_ticks, n_settings;
	int        n_resets, n_writes, n_reads, n_rejected, n_present;

	function automatic int unsigned lift(input logic [15:0] v);
		return (v == 16'd0) ? 1 : 32'(v);
	endfunction

	function automatic int unsigned span(input seq_phase_e p);
		case (p)
			SEQ_RST_LOW:    return lift(mirror.reset_low_ticks);
			SEQ_RST_WAIT:   return lift(mirror.presence_wait_ticks);
			SEQ_RST_POST:   return 32'(mirror.post_presence_ticks);
			SEQ_SLOT_LOW:   return (seq_op == REQ_WRITE && !seq_shift[0]) ?
				lift(mirror.slot_ticks) : lift(16'(mirror.short_low_ticks));
			SEQ_SLOT_HIGH,
			SEQ_READ_TAIL:  return lift(mirror.slot_ticks);
			SEQ_READ_DELAY: return 32'(mirror.sample_delay_ticks);
			SEQ_RECOVER:    return 32'(mirror.recovery_ticks);
			default:        return 1;
		endcase
	endfunction

	function automatic seq_phase_e next_phase(input seq_phase_e p);
		case (p)
			SEQ_RST_LOW: return SEQ_RST_WAIT;
			SEQ_RST_WAIT: begin
				if (seq_present)
					return SEQ_RST_POST;
				return mirror.retry_until_present ? SEQ_RST_LOW : SEQ_IDLE;
			end
			SEQ_SLOT_LOW: begin
				if (seq_op == REQ_READ)
					return SEQ_READ_DELAY;
				return seq_shift[0] ? SEQ_SLOT_HIGH : SEQ_RECOVER;
			end
			SEQ_SLOT_HIGH,
			SEQ_READ_TAIL: return SEQ_RECOVER;
			SEQ_READ_DELAY: return SEQ_READ_TAIL;
			SEQ_RECOVER: begin
				if (seq_op == REQ_WRITE)
					seq_shift = seq_shift >> 1;
				if (seq_bit == 3'd7) begin
					if (seq_op == REQ_READ)
						seq_last = seq_shift;
					return SEQ_IDLE;
				end
				seq_bit = seq_bit + 3'd1;
				return SEQ_SLOT_LOW;
			end
			default: return SEQ_IDLE;
		endcase
	endfunction

	// zero-length phases are passed over; 1 when the operation ends
	function automatic bit leave_phase();
		seq_phase_e p;
		p = seq_phase;
		do begin
			p = next_phase(p);
			seq_count = 0;
		end while (p != SEQ_IDLE && span(p) == 0);
		seq_phase = p;
		return p == SEQ_IDLE;
	endfunction

	function automatic res_t tick_status(input logic [REQ_BITS-1:0] rq,
		input logic [BYTE_BITS-1:0] wb, input logic ln);
		res_t        r;
		int unsigned len;
		r = '0;
		if (rq != REQ_TICK) begin
			if (seq_phase != SEQ_IDLE) begin
				r.rejected = 1'b1;
				n_rejected++;
			end else begin
				seq_op    = rq;
				seq_count = 0;
				seq_bit   = 3'd0;
				if (rq == REQ_RESET) begin
					seq_present = 1'b0;
					seq_phase   = SEQ_RST_LOW;
					n_resets++;
				end else begin
					seq_shift = (rq == REQ_WRITE) ? wb : '0;
					seq_phase = SEQ_SLOT_LOW;
					if (rq == REQ_WRITE)
						n_writes++;
					else
						n_reads++;
				end
			end
		end
		if (seq_phase != SEQ_IDLE) begin
			len        = span(seq_phase);
			r.busy_res = 1'b1;
			r.drive_low = (seq_phase == SEQ_RST_LOW || seq_phase == SEQ_SLOT_LOW);
			if (seq_phase == SEQ_RST_WAIT && seq_count + 1 >= len) begin
				seq_present = !ln;
				if (!ln)
					n_present++;
			end
			if (seq_phase == SEQ_READ_TAIL && seq_count == 0)
				seq_shift = {ln, seq_shift[7:1]};
			seq_count = (seq_count + 1) & COUNT_MAX;
			if (seq_count >= len || seq_count == 0)
				r.done_res = leave_phase();
		end
		r.presence  = seq_present;
		r.read_byte = seq_last;
		return r;
	endfunction

	function automatic void store_setting(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] v);
		case (idx)
			CFG_RESET_LOW:     mirror.reset_low_ticks     = v;
			CFG_PRESENCE_WAIT: mirror.presence_wait_ticks = v;
			CFG_POST_PRESENCE: mirror.post_presence_ticks = v;
			CFG_SLOT:          mirror.slot_ticks          = v;
			CFG_SHORT_LOW:     mirror.short_low_ticks     = v[7:0];
			CFG_RECOVERY:      mirror.recovery_ticks      = v[7:0];
			CFG_SAMPLE_DELAY:  mirror.sample_delay_ticks  = v[7:0];
			CFG_RETRY:         mirror.retry_until_present = v[0];
			default: ;
		endcase
	endfunction

	function automatic timing_t timing(input logic [15:0] rl, pw, pp, sl, sh, rc, sd, rt);
		timing_t t;
		t[CFG_RESET_LOW]     = rl;
		t[CFG_PRESENCE_WAIT] = pw;
		t[CFG_POST_PRESENCE] = pp;
		t[CFG_SLOT]          = sl;
		t[CFG_SHORT_LOW]     = sh;
		t[CFG_RECOVERY]      = rc;
		t[CFG_SAMPLE_DELAY]  = sd;
		t[CFG_RETRY]         = rt;
		return t;
	endfunction

	function automatic stim_row_t mk(input logic [1:0] set, input logic [REQ_BITS-1:0] rq,
		input logic [BYTE_BITS-1:0] wb, input logic ln, input bit fin);
		stim_row_t s;
		s.set = set;
		s.rq  = rq;
		s.wb  = wb;
		s.ln  = ln;
		s.fin = fin;
		s.chk = 1'b0;
		s.exp = '0;
		return s;
	endfunction

	task automatic report(input string msg);
		$display("MISMATCH %s", msg);
		n_errors++;
	endtask

	task automatic field_check(input string name, input logic [7:0] g, input logic [7:0] w);
		if (g !== w)
			report($sformatf("status %0d: %s is %0h, expected %0h", n_checked, name, g, w));
	endtask

	// called right after a rising edge; returns at the edge that took the transaction
	task automatic send_tick(input logic [REQ_BITS-1:0] rq, input logic [BYTE_BITS-1:0] wb,
		input logic ln, input bit chk, input res_t typed);
		res_t r;
		while (!calm && $urandom_range(99) < 10) begin
			tick_bus.valid <= 1'b0;
			@(posedge clk);
		end
		tick_bus.valid      <= 1'b1;
		tick_bus.req_type   <= rq;
		tick_bus.write_byte <= wb;
		tick_bus.line_level <= ln;
		do
			@(posedge clk);
		while (tick_bus.ready !== 1'b1);
		r = tick_status(rq, wb, ln);
		pending_status.push_back(chk ? typed : r);
		n_ticks++;
	endtask

	task automatic wind_down();
		while (seq_phase != SEQ_IDLE)
			send_tick(REQ_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
		tick_bus.valid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_settings(input timing_t vals);
		for (int i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= i[CFG_INDEX_BITS-1:0];
			cfg_data  <= vals[i[CFG_INDEX_BITS-1:0]];
			store_setting(i[CFG_INDEX_BITS-1:0], vals[i[CFG_INDEX_BITS-1:0]]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	always @(posedge clk) begin
		status_bus.ready <= calm || ($urandom_range(99) >= 10);
	end

	always @(posedge clk) begin
		if (arst_n && status_bus.valid && status_bus.ready) begin
			got_status = '{drive_low: status_bus.drive_low, busy_res: status_bus.busy_res,
				done_res: status_bus.done_res, presence: status_bus.presence,
				read_byte: status_bus.read_byte, rejected: status_bus.rejected};
			if (pending_status.size() == 0) begin
				report($sformatf("status %0d: transaction with nothing expected", n_checked));
			end else begin
				want_status = pending_status.pop_front();
				field_check("drive_low", 8'(got_status.drive_low), 8'(want_status.drive_low));
				field_check("busy_res", 8'(got_status.busy_res), 8'(want_status.busy_res));
				field_check("done_res", 8'(got_status.done_res), 8'(want_status.done_res));
				field_check("presence", 8'(got_status.presence), 8'(want_status.presence));
				field_check("read_byte", got_status.read_byte, want_status.read_byte);
				field_check("rejected", 8'(got_status.rejected), 8'(want_status.rejected));
			end
			n_checked++;
		end
	end

	always @(posedge clk) begin
		if ((tick_bus.valid && tick_bus.ready) || (status_bus.valid && status_bus.ready)) begin
			quiet = 0;
		end else if (++quiet >= QUIET_LIMIT) begin
			$display("watchdog: %0d cycles without a transaction, %0d status pending",
				quiet, pending_status.size());
			$display("one_wire_bus_master regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = CFG_RESET_LOW;
		cfg_data            = '0;
		tick_bus.valid      = 1'b0;
		tick_bus.req_type   = REQ_TICK;
		tick_bus.write_byte = '0;
		tick_bus.line_level = 1'b1;
		status_bus.ready    = 1'b0;
		calm                = 1'b0;
		quiet               = 0;
		mirror              = CFG_RESET_VALUE;
		seq_phase           = SEQ_IDLE;
		seq_count           = 0;
		seq_bit             = '0;
		seq_shift           = '0;
		seq_op              = REQ_TICK;
		seq_present         = 1'b0;
		seq_last            = '0;
		cur_set             = SET_DEFAULT;

		cfg_sets[SET_SMALL] = timing(16'd2, 16'd2, 16'd0, 16'd3, 16'd1, 16'd0, 16'd1, 16'd0);
		cfg_sets[SET_ZERO]  = timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
		// upper bits of the narrow registers are dropped; retry masks to 0
		cfg_sets[SET_MASK]  = timing(16'd3, 16'd2, 16'd1, 16'd4,
			16'hff02, 16'hff01, 16'hff00, 16'hfffe);

		plan.push_back(mk(SET_DEFAULT, REQ_TICK,  8'h00, 1'b1, 1'b0));
		plan[$].chk = 1'b1;
		plan.push_back(mk(SET_DEFAULT, REQ_RESET, 8'h00, 1'b1, 1'b0));
		plan[$].chk = 1'b1;
		plan[$].exp = '{drive_low: 1'b1, busy_res: 1'b1, done_res: 1'b0, presence: 1'b0,
			read_byte: 8'h00, rejected: 1'b0};
		plan.push_back(mk(SET_DEFAULT, REQ_WRITE, 8'hff, 1'b1, 1'b0));
		plan[$].chk = 1'b1;
		plan[$].exp = '{drive_low: 1'b1, busy_res: 1'b1, done_res: 1'b0, presence: 1'b0,
			read_byte: 8'h00, rejected: 1'b1};
		plan.push_back(mk(SET_DEFAULT, REQ_READ,  8'h00, 1'b0, 1'b1));
		plan.push_back(mk(SET_SMALL,   REQ_RESET, 8'h00, 1'b1, 1'b1));
		plan.push_back(mk(SET_SMALL,   REQ_RESET, 8'h00, 1'b0, 1'b1));
		plan.push_back(mk(SET_SMALL,   REQ_WRITE, 8'h00, 1'b1, 1'b1));
		plan.push_back(mk(SET_SMALL,   REQ_WRITE, 8'hff, 1'b1, 1'b1));
		plan.push_back(mk(SET_SMALL,   REQ_WRITE, 8'ha5, 1'b0, 1'b1));
		plan.push_back(mk(SET_SMALL,   REQ_READ,  8'h00, 1'b1, 1'b1));
		plan.push_back(mk(SET_SMALL,   REQ_READ,  8'hff, 1'b0, 1'b1));
		plan.push_back(mk(SET_SMALL,   REQ_TICK,  8'h00, 1'b1, 1'b0));
		plan[$].chk = 1'b1;
		plan[$].exp = '{drive_low: 1'b0, busy_res: 1'b0, done_res: 1'b0, presence: 1'b1,
			read_byte: 8'h00, rejected: 1'b0};
		// zero timings: retried resets until the line answers
		plan.push_back(mk(SET_ZERO,    REQ_RESET, 8'h00, 1'b1, 1'b0));
		plan.push_back(mk(SET_ZERO,    REQ_TICK,  8'h00, 1'b1, 1'b0));
		plan.push_back(mk(SET_ZERO,    REQ_TICK,  8'h00, 1'b1, 1'b0));
		plan.push_back(mk(SET_ZERO,    REQ_TICK,  8'h00, 1'b1, 1'b0));
		plan.push_back(mk(SET_ZERO,    REQ_TICK,  8'h00, 1'b0, 1'b1));
		plan.push_back(mk(SET_ZERO,    REQ_WRITE, 8'h5a, 1'b1, 1'b1));
		plan.push_back(mk(SET_ZERO,    REQ_READ,  8'h00, 1'b1, 1'b1));
		plan.push_back(mk(SET_MASK,    REQ_RESET, 8'h00, 1'b0, 1'b1));
		plan.push_back(mk(SET_MASK,    REQ_READ,  8'h00, 1'b1, 1'b1));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].set != cur_set) begin
				wind_down();
				calm = (plan[i].set == SET_MASK);
				load_settings(cfg_sets[plan[i].set]);
				cur_set = plan[i].set;
			end
			send_tick(plan[i].rq, plan[i].wb, plan[i].ln, plan[i].chk, plan[i].exp);
			if (plan[i].fin) begin
				while (seq_phase != SEQ_IDLE)
					send_tick(REQ_TICK, 8'h00, plan[i].ln, 1'b0, '0);
			end
		end

		for (int s = 0; s < RAND_SETS; s++) begin
			wind_down();
			calm = (s == 2);
			load_settings(timing(16'($urandom_range(6)), 16'($urandom_range(6)),
				16'($urandom_range(4)), 16'($urandom_range(6)), 16'($urandom_range(3)),
				16'($urandom_range(3)), 16'($urandom_range(3)), 16'($urandom_range(1))));
			for (int k = 0; k < RAND_ITEMS; k++) begin
				// mostly commands on an idle bus, a few colliding with a busy one
				if (seq_phase == SEQ_IDLE)
					send_tick(($urandom_range(99) < 60) ?
						REQ_BITS'($urandom_range(3, 1)) : REQ_TICK,
						8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
				else
					send_tick(($urandom_range(99) < 4) ?
						REQ_BITS'($urandom_range(3, 1)) : REQ_TICK,
						8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
			end
		end
		wind_down();
		repeat (8) @(posedge clk);

		$display("covered %0d ticks over %0d timing settings: %0d resets (%0d answered),",
			n_ticks, n_settings, n_resets, n_present);
		$display("%0d byte writes, %0d byte reads, %0d commands refused; %0d status checked",
			n_writes, n_reads, n_rejected, n_checked);
		if (n_errors == 0 && pending_status.size() == 0)
			$display("one_wire_bus_master regression: pass");
		else
			$display("one_wire_bus_master regression: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
src/owm_pkg.sv
src/owm_tick_if.sv
src/owm_status_if.sv
src/owm_cfg_regs.sv
src/owm_core.sv
src/one_wire_bus_master.sv
sim/tb_one_wire_bus_master.sv
